FILE: src/nffl_pkg.sv
package nffl_pkg;

    localparam int ARENA_UNITS = 4096;
    localparam int UNIT_BYTES  = 16;
    localparam int ADDR_W      = $clog2(ARENA_UNITS);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
    localparam int BYTES_W     = 16;
    localparam int GROW_W      = 12;
    localparam int REL_STEP_W  = ADDR_W + 1;
    localparam int ALC_STEP_W  = ADDR_W + 2;

    // walk limits before a corrupt list is given up on
    localparam logic [REL_STEP_W-1:0] REL_LIMIT = REL_STEP_W'(ARENA_UNITS + 2);
    localparam logic [ALC_STEP_W-1:0] ALC_LIMIT = ALC_STEP_W'(2 * ARENA_UNITS + 4);

    localparam logic [GROW_W-1:0] MIN_GROW_RESET = GROW_W'(1024);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;

endpackage

FILE: src/nffl_ram.sv
module nffl_ram #(
    parameter int DATA_W = 12,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/next_fit_free_list_allocator.sv
// Allocate: start, link read, an evaluate for each free-list node visited, a split step to split;
//   a grow adds a full release walk. Release: start, list walk, neighbour reads, header write, previous-node write.
// Throughput: one word at a time; the next word is taken once the result is latched.
// Cost is set by the single link read port: one list node per cycle.
// Reset: rover 0, break 1, list not started, min_grow_units 1024; the link and size
//   RAMs are not cleared (the sentinel is written by the first word).
module next_fit_free_list_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [nffl_pkg::GROW_W-1:0]  min_grow_units,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [nffl_pkg::BYTES_W-1:0] request_bytes,
    input  logic [nffl_pkg::ADDR_W-1:0]  block_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [nffl_pkg::ADDR_W-1:0]  data_address,
    output logic                         out_of_memory
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_A_LINK   = 4'd2;
    localparam logic [3:0] S_A_EVAL   = 4'd3;
    localparam logic [3:0] S_A_SPLIT  = 4'd4;
    localparam logic [3:0] S_A_RESUME = 4'd5;
    localparam logic [3:0] S_R_WALK   = 4'd6;
    localparam logic [3:0] S_R_RD2    = 4'd7;
    localparam logic [3:0] S_R_RD3    = 4'd8;
    localparam logic [3:0] S_R_CALC   = 4'd9;
    localparam logic [3:0] S_R_WRP    = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    localparam int AW = nffl_pkg::ADDR_W;
    localparam int SW = nffl_pkg::SIZE_W;

    // control state
    logic [3:0]                        state_reg;
    logic                              started_reg;
    logic [AW-1:0]                     rover_reg;
    logic [SW-1:0]                     break_reg;
    logic [nffl_pkg::GROW_W-1:0]       min_grow_reg;
    logic                              out_valid_reg;
    logic                              from_alloc_reg;   // release runs inside a grow
    logic                              inc_reg;          // step count on next link hop
    logic [nffl_pkg::REL_STEP_W-1:0]   rel_steps_reg;
    logic [nffl_pkg::ALC_STEP_W-1:0]   alc_steps_reg;

    // per-word work registers
    logic                              mode_reg;
    logic [SW-1:0]                     need_reg;
    nffl_pkg::addr_t                   addr_in_reg;
    nffl_pkg::addr_t                   p_reg;
    nffl_pkg::addr_t                   prev_reg;
    nffl_pkg::addr_t                   q_reg;
    nffl_pkg::addr_t                   hdr_reg;
    nffl_pkg::addr_t                   nx_reg;
    nffl_pkg::addr_t                   link_nx_reg;
    nffl_pkg::size_t                   size_nx_reg;
    nffl_pkg::size_t                   size_hdr_reg;
    nffl_pkg::addr_t                   new_link_hdr_reg;
    logic                              merge_lo_reg;
    nffl_pkg::size_t                   new_size_p_reg;
    nffl_pkg::addr_t                   res_addr_reg;
    logic                              res_oom_reg;
    nffl_pkg::addr_t                   out_addr_reg;
    logic                              out_oom_reg;

    // RAM ports
    logic            link_we, size_we;
    nffl_pkg::addr_t link_waddr, size_waddr, link_raddr, size_raddr;
    nffl_pkg::addr_t link_wdata, link_rd;
    nffl_pkg::size_t size_wdata, size_rd;

    nffl_ram #(.DATA_W(AW), .ADDR_W(AW)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rd)
    );

    nffl_ram #(.DATA_W(SW), .ADDR_W(AW)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .raddr (size_raddr),
        .rdata (size_rd)
    );

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign data_address  = out_addr_reg;
    assign out_of_memory = out_oom_reg;

    // request rounded up to units plus the header unit
    logic [nffl_pkg::BYTES_W:0] bytes_round;
    logic [SW-1:0]              need_in;
    assign bytes_round = {1'b0, request_bytes} + (nffl_pkg::BYTES_W+1)'(nffl_pkg::UNIT_BYTES - 1);
    assign need_in     = SW'(bytes_round >> nffl_pkg::UNIT_SHIFT) + SW'(1);

    // allocate evaluation
    nffl_pkg::size_t split_size;
    nffl_pkg::size_t grow;
    logic [SW:0]     break_sum;
    logic            arena_full;
    logic [nffl_pkg::ALC_STEP_W-1:0] alc_steps_inc;
    logic            alc_over;
    assign split_size    = size_rd - need_reg;
    assign grow          = (need_reg < {1'b0, min_grow_reg}) ? {1'b0, min_grow_reg} : need_reg;
    assign break_sum     = {1'b0, break_reg} + {1'b0, grow};
    assign arena_full    = break_sum > (SW+1)'(nffl_pkg::ARENA_UNITS);
    assign alc_steps_inc = alc_steps_reg + 1'b1;
    assign alc_over      = alc_steps_inc > nffl_pkg::ALC_LIMIT;

    // release insertion point test
    logic rel_stop;
    logic [nffl_pkg::REL_STEP_W-1:0] rel_steps_inc;
    logic rel_over;
    assign rel_stop = ((hdr_reg > p_reg) && (hdr_reg < link_rd)) ||
                      ((p_reg >= link_rd) && ((hdr_reg > p_reg) || (hdr_reg < link_rd)));
    assign rel_steps_inc = rel_steps_reg + 1'b1;
    assign rel_over      = rel_steps_inc > nffl_pkg::REL_LIMIT;

    // coalescing
    logic            merge_hi, merge_lo;
    nffl_pkg::size_t new_size_hdr;
    nffl_pkg::addr_t new_link_hdr;
    assign merge_hi     = ({2'b0, hdr_reg} + {1'b0, size_hdr_reg}) == {2'b0, nx_reg};
    assign new_size_hdr = merge_hi ? (size_hdr_reg + size_nx_reg) : size_hdr_reg;
    assign new_link_hdr = merge_hi ? link_nx_reg : nx_reg;
    assign merge_lo     = ({2'b0, p_reg} + {1'b0, size_rd}) == {2'b0, hdr_reg};

    logic            hdr_ok;
    nffl_pkg::addr_t hdr_in;
    assign hdr_in = addr_in_reg - 1'b1;
    assign hdr_ok = (addr_in_reg != '0) && (hdr_in != '0) && ({1'b0, hdr_in} < break_reg);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // RAM port steering
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = p_reg;
        link_wdata = '0;
        size_we    = 1'b0;
        size_waddr = p_reg;
        size_wdata = '0;
        link_raddr = p_reg;
        size_raddr = p_reg;
        case (state_reg)
            S_IDLE:
            begin
                // sentinel links to itself with size zero
                if (in_valid && !started_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = '0;
                    size_we    = 1'b1;
                    size_waddr = '0;
                end
            end
            S_START, S_A_RESUME:
            begin
                link_raddr = rover_reg;
            end
            S_A_LINK:
            begin
                link_raddr = link_rd;
                size_raddr = link_rd;
            end
            S_A_EVAL:
            begin
                if (size_rd >= need_reg)
                begin
                    if (size_rd == need_reg)
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rd;
                    end
                    else
                    begin
                        size_we    = 1'b1;
                        size_waddr = p_reg;
                        size_wdata = split_size;
                    end
                end
                else if (p_reg == rover_reg)
                begin
                    size_we    = !arena_full;
                    size_waddr = break_reg[AW-1:0];
                    size_wdata = grow;
                    link_raddr = rover_reg;
                end
                else
                begin
                    link_raddr = link_rd;
                    size_raddr = link_rd;
                end
            end
            S_A_SPLIT:
            begin
                size_we    = 1'b1;
                size_waddr = q_reg;
                size_wdata = need_reg;
            end
            S_R_WALK:
            begin
                link_raddr = link_rd;
                size_raddr = link_rd;
            end
            S_R_RD2:
            begin
                size_raddr = hdr_reg;
            end
            S_R_RD3:
            begin
                size_raddr = p_reg;
            end
            S_R_CALC:
            begin
                link_we    = 1'b1;
                link_waddr = hdr_reg;
                link_wdata = new_link_hdr;
                size_we    = 1'b1;
                size_waddr = hdr_reg;
                size_wdata = new_size_hdr;
            end
            S_R_WRP:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = merge_lo_reg ? new_link_hdr_reg : hdr_reg;
                size_we    = merge_lo_reg;
                size_waddr = p_reg;
                size_wdata = new_size_p_reg;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            started_reg    <= 1'b0;
            rover_reg      <= '0;
            break_reg      <= SW'(1);
            min_grow_reg   <= nffl_pkg::MIN_GROW_RESET;
            out_valid_reg  <= 1'b0;
            from_alloc_reg <= 1'b0;
            inc_reg        <= 1'b0;
            rel_steps_reg  <= '0;
            alc_steps_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_grow_reg <= min_grow_units;
            end
            // a new result loads as the old one leaves
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        started_reg <= 1'b1;
                        state_reg   <= S_START;
                    end
                end
                S_START:
                begin
                    alc_steps_reg <= '0;
                    rel_steps_reg <= '0;
                    inc_reg       <= 1'b0;
                    if (!mode_reg)
                    begin
                        from_alloc_reg <= 1'b1;
                        state_reg      <= S_A_LINK;
                    end
                    else if (hdr_ok)
                    begin
                        from_alloc_reg <= 1'b0;
                        state_reg      <= S_R_WALK;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_A_RESUME:
                begin
                    inc_reg   <= 1'b1;
                    state_reg <= S_A_LINK;
                end
                S_A_LINK:
                begin
                    if (inc_reg)
                    begin
                        alc_steps_reg <= alc_steps_inc;
                    end
                    state_reg <= (inc_reg && alc_over) ? S_DONE : S_A_EVAL;
                end
                S_A_EVAL:
                begin
                    if (size_rd >= need_reg)
                    begin
                        rover_reg <= prev_reg;
                        state_reg <= (size_rd == need_reg) ? S_DONE : S_A_SPLIT;
                    end
                    else if (p_reg == rover_reg)
                    begin
                        if (arena_full)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            break_reg     <= break_sum[SW-1:0];
                            rel_steps_reg <= '0;
                            state_reg     <= S_R_WALK;
                        end
                    end
                    else
                    begin
                        alc_steps_reg <= alc_steps_inc;
                        if (alc_over)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_A_SPLIT:
                begin
                    state_reg <= S_DONE;
                end
                S_R_WALK:
                begin
                    if (rel_stop)
                    begin
                        state_reg <= S_R_RD2;
                    end
                    else
                    begin
                        rel_steps_reg <= rel_steps_inc;
                        if (rel_over)
                        begin
                            // no insertion point: list left as is
                            state_reg <= from_alloc_reg ? S_A_RESUME : S_DONE;
                        end
                    end
                end
                S_R_RD2:
                begin
                    state_reg <= S_R_RD3;
                end
                S_R_RD3:
                begin
                    state_reg <= S_R_CALC;
                end
                S_R_CALC:
                begin
                    state_reg <= S_R_WRP;
                end
                S_R_WRP:
                begin
                    rover_reg <= p_reg;
                    state_reg <= from_alloc_reg ? S_A_RESUME : S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mode_reg    <= mode;
                need_reg    <= need_in;
                addr_in_reg <= block_address;
            end
            S_START:
            begin
                prev_reg     <= rover_reg;
                p_reg        <= rover_reg;
                hdr_reg      <= hdr_in;
                res_addr_reg <= '0;
                res_oom_reg  <= !mode_reg;
            end
            S_A_RESUME:
            begin
                prev_reg <= rover_reg;
            end
            S_A_LINK:
            begin
                p_reg <= link_rd;
            end
            S_A_EVAL:
            begin
                if (size_rd >= need_reg)
                begin
                    if (size_rd == need_reg)
                    begin
                        res_addr_reg <= p_reg + 1'b1;
                        res_oom_reg  <= (p_reg == '0);
                    end
                    q_reg <= p_reg + split_size[AW-1:0];
                end
                else if (p_reg == rover_reg)
                begin
                    hdr_reg <= break_reg[AW-1:0];
                    p_reg   <= rover_reg;
                end
                else
                begin
                    prev_reg <= p_reg;
                    p_reg    <= link_rd;
                end
            end
            S_A_SPLIT:
            begin
                res_addr_reg <= q_reg + 1'b1;
                res_oom_reg  <= (q_reg == '0);
            end
            S_R_WALK:
            begin
                if (rel_stop)
                begin
                    nx_reg <= link_rd;
                end
                else
                begin
                    p_reg <= link_rd;
                end
            end
            S_R_RD2:
            begin
                size_nx_reg <= size_rd;
                link_nx_reg <= link_rd;
            end
            S_R_RD3:
            begin
                size_hdr_reg <= size_rd;
            end
            S_R_CALC:
            begin
                new_link_hdr_reg <= new_link_hdr;
                merge_lo_reg     <= merge_lo;
                new_size_p_reg   <= size_rd + new_size_hdr;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_addr_reg <= res_addr_reg;
                    out_oom_reg  <= res_oom_reg;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

endmodule

FILE: bench/tb_next_fit_free_list_allocator.sv
module tb_next_fit_free_list_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 200000;  // cycles with no handshake before giving up
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_WORDS = 230;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Heap mirror: same free list, rover and break as the block, plus the
    // set of data areas currently handed out so releases stay legal.
    class heap_scoreboard;
        nffl_pkg::addr_t links [nffl_pkg::ARENA_UNITS];
        nffl_pkg::size_t sizes [nffl_pkg::ARENA_UNITS];
        int unsigned     rover;
        int unsigned     brk;
        bit              started;
        int unsigned     grow_min;
        nffl_pkg::addr_t live [$];
        nffl_pkg::addr_t want_addr [$];
        logic            want_oom [$];
        int              errors;

        function new();
            rover    = 0;
            brk      = 1;
            started  = 0;
            grow_min = 1024;
            errors   = 0;
        endfunction

        // address-ordered insert with merge above and below
        function void insert_free(int unsigned hdr);
            int unsigned p;
            int unsigned nx;
            int unsigned steps;
            p = rover;
            steps = 0;
            forever
            begin
                nx = links[p];
                if (hdr > p && hdr < nx)
                    break;
                if (p >= nx && (hdr > p || hdr < nx))
                    break;
                p = nx;
                steps++;
                if (steps > nffl_pkg::ARENA_UNITS + 2)
                    return;
            end
            nx = links[p];
            if (hdr + sizes[hdr] == nx)
            begin
                sizes[hdr] = sizes[hdr] + sizes[nx];
                links[hdr] = links[nx];
            end
            else
                links[hdr] = nffl_pkg::addr_t'(nx);
            if (p + sizes[p] == hdr)
            begin
                sizes[p] = sizes[p] + sizes[hdr];
                links[p] = links[hdr];
            end
            else
                links[p] = nffl_pkg::addr_t'(hdr);
            rover = p;
        endfunction

        // next-fit search; returns header unit or 0 on failure
        function int unsigned carve(int unsigned bytes);
            int unsigned need;
            int unsigned prev;
            int unsigned p;
            int unsigned steps;
            int unsigned g;
            int unsigned up;
            need  = (bytes + nffl_pkg::UNIT_BYTES - 1) / nffl_pkg::UNIT_BYTES + 1;
            prev  = rover;
            p     = links[prev];
            steps = 0;
            forever
            begin
                if (sizes[p] >= need)
                begin
                    if (sizes[p] == need)
                        links[prev] = links[p];
                    else
                    begin
                        sizes[p] = sizes[p] - nffl_pkg::size_t'(need);
                        p = (p + sizes[p]) % nffl_pkg::ARENA_UNITS;
                        sizes[p] = nffl_pkg::size_t'(need);
                    end
                    rover = prev;
                    return p;
                end
                if (p == rover)
                begin
                    g = (need < grow_min) ? grow_min : need;
                    if (brk + g > nffl_pkg::ARENA_UNITS)
                        return 0;
                    up = brk;
                    sizes[up] = nffl_pkg::size_t'(g);
                    brk += g;
                    insert_free(up);
                    p = rover;
                end
                prev = p;
                p = links[p];
                steps++;
                if (steps > 2 * nffl_pkg::ARENA_UNITS + 4)
                    return 0;
            end
        endfunction

        function void note(logic m, int unsigned bytes, int unsigned addr);
            int unsigned h;
            if (!started)
            begin
                links[0] = '0;
                sizes[0] = '0;
                rover    = 0;
                started  = 1;
            end
            if (m == MODE_ALLOC)
            begin
                h = carve(bytes);
                want_addr.push_back(nffl_pkg::addr_t'(h == 0 ? 0 : h + 1));
                want_oom.push_back(h == 0);
                if (h != 0)
                    live.push_back(nffl_pkg::addr_t'(h + 1));
            end
            else
            begin
                if (addr != 0 && addr - 1 != 0 && addr - 1 < brk)
                    insert_free(addr - 1);
                want_addr.push_back('0);
                want_oom.push_back(1'b0);
            end
        endfunction

        function void check(nffl_pkg::addr_t got_addr, logic got_oom);
            nffl_pkg::addr_t e_addr;
            logic            e_oom;
            if (want_addr.size() == 0)
            begin
                $error("result with nothing expected: data_address %0d out_of_memory %0d",
                       got_addr, got_oom);
                errors++;
                return;
            end
            e_addr = want_addr.pop_front();
            e_oom  = want_oom.pop_front();
            if (got_addr !== e_addr)
            begin
                $error("data_address: expected %0d, got %0d", e_addr, got_addr);
                errors++;
            end
            if (got_oom !== e_oom)
            begin
                $error("out_of_memory: expected %0d, got %0d", e_oom, got_oom);
                errors++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [nffl_pkg::GROW_W-1:0]   min_grow_units = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          mode = MODE_ALLOC;
    logic [nffl_pkg::BYTES_W-1:0]  request_bytes = '0;
    logic [nffl_pkg::ADDR_W-1:0]   block_address = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [nffl_pkg::ADDR_W-1:0]   data_address;
    logic                          out_of_memory;

    heap_scoreboard sb = new();
    bit  calm = 1'b0;       // when set neither side idles
    int  quiet_cycles = 0;

    next_fit_free_list_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .min_grow_units (min_grow_units),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .block_address  (block_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_address   (data_address),
        .out_of_memory  (out_of_memory)
    );

    always #1 clk = ~clk;

    // result side: random back-pressure, ~23% stall
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 23);

    // result check and watchdog, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check(data_address, out_of_memory);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one input word; optional gap first, valid held until taken
    task automatic send_word(logic m, int unsigned bytes, int unsigned addr);
        if (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        request_bytes <= nffl_pkg::BYTES_W'(bytes);
        block_address <= nffl_pkg::ADDR_W'(addr);
        do @(posedge clk); while (!in_ready);
        sb.note(m, bytes, addr);
    endtask

    // hand back a live area, picked at random
    task automatic release_live();
        int idx;
        nffl_pkg::addr_t a;
        idx = $urandom_range(sb.live.size() - 1);
        a = sb.live[idx];
        sb.live.delete(idx);
        send_word(MODE_RELEASE, $urandom_range(16'hFFFF), a);
    endtask

    // bad release: address 0, header 0, or past the break
    task automatic release_bogus();
        int unsigned a;
        case ($urandom_range(2))
            0: a = 0;
            1: a = 1;
            default: a = (sb.brk < nffl_pkg::ARENA_UNITS - 1) ?
                         $urandom_range(nffl_pkg::ARENA_UNITS - 1, sb.brk + 1) : 0;
        endcase
        send_word(MODE_RELEASE, $urandom_range(16'hFFFF), a);
    endtask

    task automatic random_word();
        int unsigned r;
        int unsigned bytes;
        r = $urandom_range(99);
        if (r < 4)
            release_bogus();
        else if (r < 48 && sb.live.size() > 0)
            release_live();
        else
        begin
            r = $urandom_range(99);
            if (r < 75)      bytes = $urandom_range(256);
            else if (r < 95) bytes = $urandom_range(8192);
            else             bytes = $urandom_range(16'hFFFF);
            send_word(MODE_ALLOC, bytes, $urandom_range(nffl_pkg::ARENA_UNITS - 1));
        end
    endtask

    // register write only with nothing in flight
    task automatic write_grow(logic [nffl_pkg::GROW_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.want_addr.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid      <= 1'b1;
        min_grow_units <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.grow_min = v;
    endtask

    logic [nffl_pkg::GROW_W-1:0] grow_plan [6] =
        '{12'd1, 12'd4095, 12'd16, 12'd1024, 12'd200, 12'd64};

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first word is a release, then edge sizes and bad releases
        send_word(MODE_RELEASE, 16'hFFFF, 0);
        send_word(MODE_ALLOC, 0, 12'hFFF);
        send_word(MODE_ALLOC, 1, 0);
        send_word(MODE_ALLOC, 16, 0);
        send_word(MODE_ALLOC, 17, 0);
        send_word(MODE_ALLOC, 16'hFFFF, 0);                      // more than the arena
        send_word(MODE_RELEASE, 0, 1);                           // header at the sentinel
        send_word(MODE_RELEASE, 0, nffl_pkg::ARENA_UNITS - 1);   // past the break
        send_word(MODE_ALLOC, 4000, 0);
        release_live();
        send_word(MODE_ALLOC, 16, 0);                            // likely exact fit
        while (sb.live.size() > 0)
            release_live();                                      // merges back to one block
        send_word(MODE_ALLOC, 16000, 0);
        send_word(MODE_ALLOC, 32000, 0);                         // forces a grow
        send_word(MODE_ALLOC, 48000, 0);                         // arena full
        release_live();
        release_live();

        foreach (grow_plan[i])
        begin
            write_grow(grow_plan[i]);
            calm = (i == 3);
            repeat (PHASE_WORDS) random_word();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.want_addr.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.want_addr.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
